// File: src/cct_pkg.sv
package cct_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned MAX_CH = 8;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_IDLE  = 2'd3
    } t_kind;

    // register map
    localparam logic [3:0] ADDR_MODE    = 4'd0;
    localparam logic [3:0] ADDR_OUTCTL  = 4'd1;
    localparam logic [3:0] ADDR_EDGECTL = 4'd2;
    localparam logic [3:0] ADDR_IRQ_EN  = 4'd3;
    localparam logic [3:0] ADDR_FLAGS   = 4'd4;
    localparam logic [3:0] ADDR_OVF     = 4'd5;
    localparam logic [3:0] ADDR_COUNTER = 4'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESCALE = 2'd0;
    localparam logic [1:0] CFG_TIMER_EN = 2'd1;
    localparam logic [1:0] CFG_OVF_IRQ  = 2'd2;

    // compare output actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_TOGGLE = 2'd1;
    localparam logic [1:0] ACT_LOW    = 2'd2;
    localparam logic [1:0] ACT_HIGH   = 2'd3;

    // capture edge select bits
    localparam int unsigned EDGE_RISE_BIT = 0;
    localparam int unsigned EDGE_FALL_BIT = 1;

    typedef struct packed {
        logic       accept;
        logic       wr_value;
        logic       compare;
        logic [1:0] edge_sel;
        logic       rise;
        logic       fall;
        logic       advance;
    } t_ch_ctrl;

    typedef struct packed {
        logic capture;
        logic match;
    } t_ch_event;

endpackage

// File: src/cct_channel.sv
module cct_channel
    import cct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ch_ctrl          i_ctrl,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [DATA_W-1:0] i_counter,
    input  logic [DATA_W-1:0] i_counter_next,
    output logic [DATA_W-1:0] o_value,
    output t_ch_event         o_event
);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;
    logic [DATA_W-1:0] w_after_wr;
    logic              w_hit;

    always_comb begin
        w_after_wr = i_ctrl.wr_value ? i_write_data : r_value;
        w_hit = i_ctrl.accept && !i_ctrl.compare &&
                ((i_ctrl.edge_sel[EDGE_RISE_BIT] && i_ctrl.rise) ||
                 (i_ctrl.edge_sel[EDGE_FALL_BIT] && i_ctrl.fall));
        // capture latches the counter from before the beat
        n_value = w_hit ? i_counter : w_after_wr;
        o_event.capture = w_hit;
        o_event.match = i_ctrl.accept && i_ctrl.advance && i_ctrl.compare &&
                        (n_value == i_counter_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_ctrl.accept) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// File: src/capture_compare_timer.sv
// channel   signals                                               direction
// in        i_in_valid / o_in_ready, i_kind, i_reg_address,       in
//           i_write_data, i_pin_levels
// out       o_out_valid / i_out_ready, o_read_data, o_pin_drive,  out
//           o_pin_driven, o_irq
// cfg       i_cfg_we, i_cfg_index, i_cfg_data                     in
//
// one beat per cycle while results are taken: each accepted beat updates the
// timer state and the result register at once, so the result shows next cycle.
// the input is ready whenever the result register is empty or being taken;
// a stalled result holds the input back only for that cycle pattern.
// synchronous active-low reset clears all state, config and the result valid.
module capture_compare_timer
    import cct_pkg::*;
#(
    parameter int unsigned CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [3:0]        i_reg_address,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [7:0]        i_pin_levels,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_data,
    output logic [7:0]        o_pin_drive,
    output logic [7:0]        o_pin_driven,
    output logic              o_irq,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [2:0]        i_cfg_data
);

    localparam logic [7:0]  CH_MASK   = 8'((1 << CHANNELS) - 1);
    localparam logic [15:0] PAIR_MASK = 16'((1 << (2 * CHANNELS)) - 1);

    // configuration
    logic [2:0] r_shift;
    logic       r_timer_en;
    logic       r_ovf_irq_en;

    // state
    logic [DATA_W-1:0] r_counter, n_counter;
    logic [6:0]        r_pcount, n_pcount;
    logic [7:0]        r_mode, n_mode;
    logic [15:0]       r_outctl, n_outctl;
    logic [15:0]       r_edgectl, n_edgectl;
    logic [7:0]        r_irq_en, n_irq_en;
    logic [7:0]        r_flags, n_flags;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_last, n_last;
    logic [7:0]        r_pin, n_pin;

    // result register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic [7:0]        r_drive, n_drive;
    logic [7:0]        r_driven, n_driven;
    logic              r_irq, n_irq;

    logic        w_accept;
    t_kind       w_kind;
    logic        w_wr;
    logic        w_advance;
    logic [6:0]  w_last;
    logic [7:0]  w_pins;
    logic [7:0]  w_rise;
    logic [7:0]  w_fall;
    logic [7:0]  w_capture;
    logic [7:0]  w_match;
    logic [DATA_W-1:0] w_value [MAX_CH];
    t_ch_ctrl    w_ctrl [MAX_CH];
    t_ch_event   w_event [MAX_CH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_kind     = t_kind'(i_kind);
    assign w_wr       = (w_kind == KIND_WRITE);

    always_comb begin
        w_pins = i_pin_levels & CH_MASK;
        w_rise = w_pins & ~r_last;
        w_fall = ~w_pins & r_last;
        w_last = (7'd1 << r_shift) - 7'd1;
        w_advance = (w_kind == KIND_TICK) && r_timer_en && (r_pcount >= w_last);
        n_counter = w_advance ? r_counter + 16'd1 : r_counter;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_CH; g++) begin : g_ch
            if (g < CHANNELS) begin : g_on
                assign w_ctrl[g] = '{
                    accept:   w_accept,
                    wr_value: w_wr && (i_reg_address == 4'(8 + g)),
                    compare:  n_mode[g],
                    edge_sel: n_edgectl[2*g +: 2],
                    rise:     w_rise[g],
                    fall:     w_fall[g],
                    advance:  w_advance
                };
                cct_channel u_channel (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_ctrl         (w_ctrl[g]),
                    .i_write_data   (i_write_data),
                    .i_counter      (r_counter),
                    .i_counter_next (n_counter),
                    .o_value        (w_value[g]),
                    .o_event        (w_event[g])
                );
            end else begin : g_off
                assign w_ctrl[g]  = '0;
                assign w_value[g] = '0;
                assign w_event[g] = '0;
            end
            assign w_capture[g] = w_event[g].capture;
            assign w_match[g]   = w_event[g].match;
        end
    endgenerate

    always_comb begin
        n_mode    = r_mode;
        n_outctl  = r_outctl;
        n_edgectl = r_edgectl;
        n_irq_en  = r_irq_en;
        n_flags   = r_flags;
        n_ovf     = r_ovf;
        n_rd      = '0;

        if (w_kind == KIND_READ) begin
            priority if (i_reg_address[3]) begin
                n_rd = w_value[i_reg_address[2:0]];
            end else begin
                unique case (i_reg_address)
                    ADDR_MODE:    n_rd = {8'd0, r_mode};
                    ADDR_OUTCTL:  n_rd = r_outctl;
                    ADDR_EDGECTL: n_rd = r_edgectl;
                    ADDR_IRQ_EN:  n_rd = {8'd0, r_irq_en};
                    ADDR_FLAGS:   n_rd = {8'd0, r_flags};
                    ADDR_OVF:     n_rd = {15'd0, r_ovf};
                    ADDR_COUNTER: n_rd = r_counter;
                    default:      n_rd = '0;
                endcase
            end
        end

        if (w_wr) begin
            unique case (i_reg_address)
                ADDR_MODE:    n_mode    = i_write_data[7:0] & CH_MASK;
                ADDR_OUTCTL:  n_outctl  = i_write_data & PAIR_MASK;
                ADDR_EDGECTL: n_edgectl = i_write_data & PAIR_MASK;
                ADDR_IRQ_EN:  n_irq_en  = i_write_data[7:0] & CH_MASK;
                ADDR_FLAGS:   n_flags   = r_flags & ~i_write_data[7:0];
                ADDR_OVF:     n_ovf     = r_ovf & ~i_write_data[0];
                default:      ;
            endcase
        end

        // sets win over the write-one clears above
        n_flags = n_flags | w_capture | w_match;
        if (w_advance && (n_counter == '0)) begin
            n_ovf = 1'b1;
        end

        n_pcount = r_pcount;
        if ((w_kind == KIND_TICK) && r_timer_en) begin
            n_pcount = w_advance ? 7'd0 : r_pcount + 7'd1;
        end

        n_last = w_pins;

        n_pin = r_pin;
        for (int i = 0; i < MAX_CH; i++) begin
            if (w_match[i]) begin
                unique case (n_outctl[2*i +: 2])
                    ACT_TOGGLE: n_pin[i] = ~r_pin[i];
                    ACT_LOW:    n_pin[i] = 1'b0;
                    ACT_HIGH:   n_pin[i] = 1'b1;
                    ACT_NONE:   ;
                endcase
            end
        end

        for (int i = 0; i < MAX_CH; i++) begin
            n_driven[i] = n_mode[i] && (n_outctl[2*i +: 2] != ACT_NONE);
        end
        n_drive = n_pin & n_driven;
        n_irq   = ((n_flags & n_irq_en) != 8'd0) || (n_ovf && r_ovf_irq_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= '0;
            r_timer_en   <= 1'b0;
            r_ovf_irq_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRESCALE: r_shift      <= i_cfg_data;
                CFG_TIMER_EN: r_timer_en   <= i_cfg_data[0];
                CFG_OVF_IRQ:  r_ovf_irq_en <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_pcount  <= '0;
            r_mode    <= '0;
            r_outctl  <= '0;
            r_edgectl <= '0;
            r_irq_en  <= '0;
            r_flags   <= '0;
            r_ovf     <= 1'b0;
            r_last    <= '0;
            r_pin     <= '0;
        end else if (w_accept) begin
            r_counter <= n_counter;
            r_pcount  <= n_pcount;
            r_mode    <= n_mode;
            r_outctl  <= n_outctl;
            r_edgectl <= n_edgectl;
            r_irq_en  <= n_irq_en;
            r_flags   <= n_flags;
            r_ovf     <= n_ovf;
            r_last    <= n_last;
            r_pin     <= n_pin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd     <= n_rd;
            r_drive  <= n_drive;
            r_driven <= n_driven;
            r_irq    <= n_irq;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_rd;
    assign o_pin_drive  = r_drive;
    assign o_pin_driven = r_driven;
    assign o_irq        = r_irq;

endmodule
